// ===== sv/pfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the paged flash emulator: item layouts,
// operation and status codes, flash base address and erased byte value.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Absolute address at which the flash array is mapped
  localparam logic [19:0] FLASH_BASE  = 20'h80000;
  // Value of every byte of an erased page
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_ERASE = 2'd2
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_ERASED = 2'd1,
    ST_PARAM      = 2'd2,
    ST_BOUNDS     = 2'd3
  } status_t;

  // One input item: a single byte of a transfer, or an erase command
  typedef struct packed {
    logic [1:0]  mode;
    logic [19:0] address;
    logic [13:0] length;
    logic [12:0] byte_index;
    logic [7:0]  data_byte;
  } req_item_t;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       last;
  } rsp_item_t;

endpackage

// ===== sv/pfe_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_req_if
// Valid/ready channel that carries input items into the flash emulator.
// ----------------------------------------------------------------------------
interface pfe_req_if;
  import pfe_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);

endinterface

// ===== sv/pfe_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_rsp_if
// Valid/ready channel that carries result items out of the flash emulator.
// ----------------------------------------------------------------------------
interface pfe_rsp_if;
  import pfe_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);

endinterface

// ===== sv/pfe_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_mem
// Single-port byte-wide flash storage with one access per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module pfe_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write on request, register the read data every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/pfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer of the flash emulator. One cursor register and one shared adder
// walk the memory for the reset clearing pass, the page start search, the
// page erase fill and the erased check scan; the same sequencer performs
// the byte accesses and loads the result register.
// ----------------------------------------------------------------------------
module pfe_ctrl #(
  parameter int MEMORY_BYTES = 8192,
  parameter int PAGE_BYTES   = 2048,
  parameter int AW           = 13
) (
  input  logic          clk,
  input  logic          rst,
  pfe_req_if.sink       req,
  pfe_rsp_if.source     rsp,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output logic [7:0]    mem_wdata,
  input  logic [7:0]    mem_rdata
);
  import pfe_pkg::*;

  // Cursor width: holds offsets up to one page past the memory end
  localparam int CW = $clog2(MEMORY_BYTES + PAGE_BYTES + 1);
  // Width of absolute address arithmetic
  localparam int WW = 21;

  localparam logic [CW-1:0] MEM_C  = CW'(MEMORY_BYTES);
  localparam logic [CW-1:0] PAGE_C = CW'(PAGE_BYTES);
  localparam logic [WW-1:0] BASE_W = WW'(FLASH_BASE);
  localparam logic [WW-1:0] END_W  = BASE_W + WW'(MEMORY_BYTES);
  localparam logic [WW-1:0] MEM_W  = WW'(MEMORY_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_FILL,
    S_SCAN,
    S_SCAN_END,
    S_ACCESS,
    S_READ_WAIT,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    PH_ERASE,
    PH_PAGE1,
    PH_PAGE2
  } phase_t;

  state_t    state;
  phase_t    phase;
  req_item_t itm;
  logic [CW-1:0] cur;
  logic [CW-1:0] lim;
  logic [CW-1:0] tgt;
  logic      chk_valid;
  logic      bad;
  status_t   xfer_status;
  status_t   res_status;
  logic [7:0] res_rd;
  logic      res_last;
  logic      out_valid;
  rsp_item_t out_item;

  logic [CW-1:0] cur_sum;
  logic [WW-1:0] addr_w;
  logic [WW-1:0] len_w;
  logic [WW-1:0] off_w;
  logic [WW-1:0] last_off_w;
  logic [WW-1:0] acc_w;
  logic          addr_lo;
  logic          addr_in;
  logic          xfer_oob;
  logic          guard;
  logic          bad_now;
  logic          idx_last;
  logic          do_write;

  // Shared adder: page steps during the search, single bytes otherwise
  assign cur_sum = cur + ((state == S_FIND) ? PAGE_C : CW'(1));

  // Address decode of the latched item
  assign addr_w     = WW'(itm.address);
  assign len_w      = WW'(itm.length);
  assign off_w      = addr_w - BASE_W;
  assign last_off_w = off_w + len_w - WW'(1);
  assign acc_w      = off_w + WW'(itm.byte_index);
  assign addr_lo    = (itm.address < FLASH_BASE);
  assign addr_in    = !addr_lo && (addr_w < END_W);
  assign xfer_oob   = !addr_in || ((addr_w + len_w) > END_W);
  assign guard      = !addr_lo && (acc_w < MEM_W);
  assign idx_last   = ((14'(itm.byte_index) + 14'd1) >= itm.length);
  assign bad_now    = bad || (chk_valid && (mem_rdata != ERASED_BYTE));

  // Memory port: sweeps use the cursor, byte accesses the computed offset
  assign do_write  = (state == S_ACCESS) && (itm.mode == MODE_WRITE) &&
                     (xfer_status == ST_OK) && guard;
  assign mem_we    = (state == S_CLEAR) || (state == S_FILL) || do_write;
  assign mem_addr  = (state == S_ACCESS) ? acc_w[AW-1:0] : cur[AW-1:0];
  assign mem_wdata = (state == S_ACCESS) ? itm.data_byte : ERASED_BYTE;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.item  = out_item;

  // Sequencer, result register and erased check flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cur         <= '0;
      out_valid   <= 1'b0;
      chk_valid   <= 1'b0;
      xfer_status <= ST_OK;
    end else begin
      // Drop the result once its transfer completes, unless a new one loads
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      chk_valid <= (state == S_SCAN);
      if (chk_valid && (mem_rdata != ERASED_BYTE)) begin
        bad <= 1'b1;
      end

      case (state)
        S_CLEAR: begin
          cur <= cur_sum;
          if (cur_sum == MEM_C) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            itm   <= req.item;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_rd   <= '0;
          res_last <= 1'b1;
          cur      <= '0;
          case (itm.mode)
            MODE_ERASE: begin
              if (!addr_in) begin
                res_status <= ST_BOUNDS;
                state      <= S_RESP;
              end else begin
                tgt   <= off_w[CW-1:0];
                phase <= PH_ERASE;
                state <= S_FIND;
              end
            end
            MODE_READ, MODE_WRITE: begin
              if (itm.byte_index != '0) begin
                state <= S_ACCESS;
              end else if (xfer_oob) begin
                xfer_status <= ST_BOUNDS;
                state       <= S_ACCESS;
              end else if (itm.length == '0) begin
                xfer_status <= ST_PARAM;
                state       <= S_ACCESS;
              end else if (itm.mode == MODE_WRITE) begin
                bad   <= 1'b0;
                tgt   <= off_w[CW-1:0];
                phase <= PH_PAGE1;
                state <= S_FIND;
              end else begin
                xfer_status <= ST_OK;
                state       <= S_ACCESS;
              end
            end
            default: begin
              res_status <= ST_PARAM;
              state      <= S_RESP;
            end
          endcase
        end

        // Step the cursor a page at a time to the start of the target page
        S_FIND: begin
          if (cur_sum <= tgt) begin
            cur <= cur_sum;
          end else begin
            lim   <= (cur_sum > MEM_C) ? MEM_C : cur_sum;
            state <= (phase == PH_ERASE) ? S_FILL : S_SCAN;
          end
        end

        S_FILL: begin
          cur <= cur_sum;
          if (cur_sum == lim) begin
            res_status <= ST_OK;
            state      <= S_RESP;
          end
        end

        S_SCAN: begin
          cur <= cur_sum;
          if (cur_sum == lim) begin
            state <= S_SCAN_END;
          end
        end

        // Last read data of the page is checked through bad_now
        S_SCAN_END: begin
          if (phase == PH_PAGE1) begin
            tgt   <= last_off_w[CW-1:0];
            phase <= PH_PAGE2;
            cur   <= '0;
            state <= S_FIND;
          end else begin
            xfer_status <= bad_now ? ST_NOT_ERASED : ST_OK;
            state       <= S_ACCESS;
          end
        end

        S_ACCESS: begin
          res_status <= xfer_status;
          res_last   <= (xfer_status != ST_OK) || idx_last;
          res_rd     <= '0;
          if ((xfer_status == ST_OK) && guard && (itm.mode == MODE_READ)) begin
            state <= S_READ_WAIT;
          end else begin
            state <= S_RESP;
          end
        end

        S_READ_WAIT: begin
          res_rd <= mem_rdata;
          state  <= S_RESP;
        end

        // Load the result register once it is free
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_item.status    <= res_status;
            out_item.read_byte <= res_rd;
            out_item.last      <= res_last;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/paged_flash_emulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_flash_emulator_top
// Paged flash emulator: MEMORY_BYTES mapped at 0x80000 in pages of
// PAGE_BYTES, byte-per-item read and write transfers, page erase.
// ----------------------------------------------------------------------------
// Sequence: a plain byte passes decode and access before the result register loads,
//   a read adding a registered memory read wait; a write start byte adds two page
//   searches and two page scans; erase adds a search and a fill.
// Throughput: one item at a time; the next is taken the cycle after the result loads.
// Reset: a clearing pass writes 0xFF to all MEMORY_BYTES bytes, one per cycle,
//   with req.ready low; then the block accepts items.
// ----------------------------------------------------------------------------
module paged_flash_emulator_top #(
  parameter int MEMORY_BYTES = 8192,
  parameter int PAGE_BYTES   = 2048
) (
  input  logic      clk,
  input  logic      rst,
  pfe_req_if.sink   req,
  pfe_rsp_if.source rsp
);
  import pfe_pkg::*;

  localparam int AW = $clog2(MEMORY_BYTES);

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  pfe_ctrl #(
    .MEMORY_BYTES (MEMORY_BYTES),
    .PAGE_BYTES   (PAGE_BYTES),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  pfe_mem #(
    .DEPTH (MEMORY_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // No memory write while the block waits for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !req.ready)
    else $error("memory written while idle");

  // Each accepted item takes the block busy in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready held after input transfer");

  // An error result always ends the transfer
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.item.status != ST_OK)) |-> rsp.item.last)
    else $error("error result without last");

  // A failed item returns no data
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.item.status != ST_OK)) |-> (rsp.item.read_byte == 8'h00))
    else $error("error result carries read data");

endmodule
